### design/sha1_pkg.sv
// ============================================================================
// sha1_pkg
// Shared types, round constants and state encodings for the SHA-1 hasher.
// ============================================================================
`default_nettype none

package sha1_pkg;

    // Round constants, one for each group of twenty rounds.
    localparam logic [31:0] K_R0 = 32'h5a827999;
    localparam logic [31:0] K_R1 = 32'h6ed9eba1;
    localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_R3 = 32'hca62c1d6;

    // Initial chaining value H0..H4.
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam int unsigned NUM_WORDS  = 16;
    localparam int unsigned NUM_DIGEST = 5;
    localparam int unsigned NUM_ROUNDS = 80;

    // Padding constants: the marker byte and the byte offset of the length.
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;

    localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);
    localparam logic [2:0] LAST_INDEX = 3'(NUM_DIGEST - 1);

    // Input beat: one message byte plus its flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha1_in_t;

    // Output beat: one digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha1_out_t;

    // Writes into the message block buffer of the compression core.
    typedef struct packed {
        logic        byte_we;
        logic [5:0]  byte_pos;
        logic [7:0]  byte_data;
        logic        len_we;
        logic [63:0] len_bits;
    } sha1_load_t;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_OUT
    } sha1_state_t;

    // Compression core states.
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_ADD
    } sha1_core_state_t;

endpackage

`default_nettype wire

### design/sha1_round.sv
// ============================================================================
// sha1_round
// One SHA-1 round: boolean function, constant select and the five-way add.
// ============================================================================
`default_nettype none

module sha1_round (
    input  wire logic [6:0]  round,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] c,
    input  wire logic [31:0] d,
    input  wire logic [31:0] e,
    input  wire logic [31:0] wt,
    output logic      [31:0] a_next,
    output logic      [31:0] b_next,
    output logic      [31:0] c_next,
    output logic      [31:0] d_next,
    output logic      [31:0] e_next
);
    import sha1_pkg::*;

    logic [31:0] f;
    logic [31:0] k;

    // Select the boolean function and constant for this group of rounds.
    always_comb
    begin
        if (round < 7'd20)
        begin
            f = (b & c) | (~b & d);
            k = K_R0;
        end
        else if (round < 7'd40)
        begin
            f = b ^ c ^ d;
            k = K_R1;
        end
        else if (round < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = K_R2;
        end
        else
        begin
            f = b ^ c ^ d;
            k = K_R3;
        end
    end

    // Rotate the working variables and form the new A.
    assign a_next = {a[26:0], a[31:27]} + f + e + k + wt;
    assign b_next = a;
    assign c_next = {b[1:0], b[31:2]};
    assign d_next = c;
    assign e_next = d;

endmodule

`default_nettype wire

### design/sha1_core.sv
// ============================================================================
// sha1_core
// Iterative compression: block buffer, message schedule window, working
// variables and chaining value, one round per cycle.
// ============================================================================
`default_nettype none

module sha1_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha1_pkg::sha1_load_t  load,
    input  wire logic                  start,
    input  wire logic                  chain_init,
    input  wire logic [2:0]            chain_idx,
    output logic                       done,
    output logic      [31:0]           chain_word
);
    import sha1_pkg::*;

    sha1_core_state_t cs_reg, cs_next;
    logic [6:0]       round_reg, round_next;

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [NUM_WORDS];
    logic [31:0] h_reg [NUM_DIGEST];

    logic [31:0] a_rnd, b_rnd, c_rnd, d_rnd, e_rnd;
    logic [31:0] w_new;
    logic [4:0]  lane_shift;

    // Shared round unit.
    sha1_round u_round (
        .round  (round_reg),
        .a      (a_reg),
        .b      (b_reg),
        .c      (c_reg),
        .d      (d_reg),
        .e      (e_reg),
        .wt     (w_reg[0]),
        .a_next (a_rnd),
        .b_next (b_rnd),
        .c_next (c_rnd),
        .d_next (d_rnd),
        .e_next (e_rnd)
    );

    // Schedule word sixteen rounds ahead of the window head.
    always_comb
    begin
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    // The first byte of a word goes to its most significant lane.
    assign lane_shift = 5'd24 - {load.byte_pos[1:0], 3'b000};

    // Sequencer next state.
    always_comb
    begin
        cs_next    = cs_reg;
        round_next = round_reg;
        case (cs_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    cs_next    = CS_ROUND;
                    round_next = '0;
                end
            end
            CS_ROUND:
            begin
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    cs_next = CS_ADD;
                end
            end
            CS_ADD:
            begin
                cs_next = CS_IDLE;
            end
            default:
            begin
                cs_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg    <= CS_IDLE;
            round_reg <= '0;
        end
        else
        begin
            cs_reg    <= cs_next;
            round_reg <= round_next;
        end
    end

    // Working variables and message schedule window.
    always_ff @(posedge clk)
    begin
        if (cs_reg == CS_IDLE && start)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cs_reg == CS_ROUND)
        begin
            a_reg <= a_rnd;
            b_reg <= b_rnd;
            c_reg <= c_rnd;
            d_reg <= d_rnd;
            e_reg <= e_rnd;
        end

        if (cs_reg == CS_ROUND)
        begin
            for (int i = 0; i < NUM_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[NUM_WORDS - 1] <= w_new;
        end
        else
        begin
            if (load.byte_we)
            begin
                w_reg[load.byte_pos[5:2]][lane_shift +: 8] <= load.byte_data;
            end
            if (load.len_we)
            begin
                w_reg[14] <= load.len_bits[63:32];
                w_reg[15] <= load.len_bits[31:0];
            end
        end
    end

    // Chaining value: reset to the initial constants, fold in each block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIGEST; i++)
            begin
                h_reg[i] <= H_INIT[i];
            end
        end
        else if (cs_reg == CS_ADD)
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
        else if (chain_init)
        begin
            for (int i = 0; i < NUM_DIGEST; i++)
            begin
                h_reg[i] <= H_INIT[i];
            end
        end
    end

    assign done       = (cs_reg == CS_ADD);
    assign chain_word = h_reg[chain_idx];

endmodule

`default_nettype wire

### design/sha1_message_hasher_top.sv
// ============================================================================
// sha1_message_hasher_top
// SHA-1 over a byte stream: byte packing, padding sequencer, digest output.
// ============================================================================
// Usage:
//   The item channel (item_valid/item_ready/item) takes one beat per message
//   byte; byte_present marks a real byte and end_of_message closes the
//   message. The result channel (result_valid/result_ready/result) returns
//   five beats per message, H0 first, with last_word set on H4.
//   A byte that does not fill a block is written straight into the block
//   buffer. The beat that fills a 64-byte block starts a compression (start,
//   80 rounds on the shared round unit, final add), during which item_ready
//   is low. At the end of a message the padding bytes are written one per
//   cycle, except while a compression runs, then the length words, with one
//   or two compressions, before the digest appears; the five words then
//   leave at one per cycle while the receiver accepts them.
//   The output register lets the next message start while the last digest
//   word waits; a stalled receiver holds the remaining words and the block
//   waits in its output state.
//   Reset clears the byte count, the length and the sequencer and loads the
//   initial chaining value; the block comes out of it idle and ready for bytes.
// ============================================================================
`default_nettype none

module sha1_message_hasher_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire sha1_pkg::sha1_in_t   item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output sha1_pkg::sha1_out_t       result
);
    import sha1_pkg::*;

    sha1_state_t state_reg, state_next;
    sha1_state_t after_reg, after_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [60:0] len_reg, len_next;
    logic [2:0]  widx_reg, widx_next;
    logic        out_valid_reg, out_valid_next;
    sha1_out_t   out_reg, out_next;

    sha1_load_t  load;
    logic        start;
    logic        chain_init;
    logic        core_done;
    logic [31:0] chain_word;
    logic        out_free;

    sha1_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .start      (start),
        .chain_init (chain_init),
        .chain_idx  (widx_reg),
        .done       (core_done),
        .chain_word (chain_word)
    );

    assign out_free = !out_valid_reg || result_ready;

    // Sequencer: byte intake, padding, length, digest readout.
    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        widx_next      = widx_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        item_ready     = 1'b0;
        start          = 1'b0;
        chain_init     = 1'b0;
        load.byte_we   = 1'b0;
        load.byte_pos  = cnt_reg;
        load.byte_data = item.data_byte;
        load.len_we    = 1'b0;
        load.len_bits  = {len_reg, 3'b000};

        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item.end_of_message)
                    begin
                        state_next = ST_PAD80;
                    end
                    if (item.byte_present)
                    begin
                        load.byte_we = 1'b1;
                        len_next     = len_reg + 61'd1;
                        cnt_next     = cnt_reg + 6'd1;
                        if (cnt_reg == LAST_POS)
                        begin
                            start      = 1'b1;
                            state_next = ST_COMP;
                            after_next = item.end_of_message ? ST_PAD80 : ST_IDLE;
                        end
                    end
                end
            end
            ST_PAD80:
            begin
                load.byte_we   = 1'b1;
                load.byte_data = PAD_MARK;
                cnt_next       = cnt_reg + 6'd1;
                state_next     = ST_PADZ;
                if (cnt_reg == LAST_POS)
                begin
                    start      = 1'b1;
                    state_next = ST_COMP;
                    after_next = ST_PADZ;
                end
            end
            ST_PADZ:
            begin
                if (cnt_reg == LEN_OFFSET)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    load.byte_we   = 1'b1;
                    load.byte_data = '0;
                    cnt_next       = cnt_reg + 6'd1;
                    if (cnt_reg == LAST_POS)
                    begin
                        start      = 1'b1;
                        state_next = ST_COMP;
                        after_next = ST_PADZ;
                    end
                end
            end
            ST_LEN:
            begin
                load.len_we = 1'b1;
                start       = 1'b1;
                cnt_next    = '0;
                state_next  = ST_COMP;
                after_next  = ST_OUT;
            end
            ST_COMP:
            begin
                if (core_done)
                begin
                    state_next = after_reg;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.digest_word = chain_word;
                    out_next.word_index  = widx_reg;
                    out_next.last_word   = (widx_reg == LAST_INDEX);
                    widx_next            = widx_reg + 3'd1;
                    if (widx_reg == LAST_INDEX)
                    begin
                        widx_next  = '0;
                        len_next   = '0;
                        cnt_next   = '0;
                        chain_init = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            after_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            len_reg       <= '0;
            widx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            widx_reg      <= widx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
